// ===== rtl/core/szsz_correlation_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// szsz correlation accumulator assertion macros
// clocked on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef SZSZ_CORRELATION_ACCUMULATOR_DEFINES_SVH
`define SZSZ_CORRELATION_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SZSZ_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("szsz assertion failed");
`define SZSZ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("szsz assertion failed");
`else
`define SZSZ_ASSERT(label, prop)
`define SZSZ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/szsz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szsz_pkg
// shared types and constants of the Sz-Sz correlation accumulator
// ----------------------------------------------------------------------------
package szsz_pkg;

   localparam int IDX_W      = 16;
   localparam int IDX_SEL_W  = 4;
   localparam int SITE_W     = 4;
   localparam int ACC_W      = 64;
   localparam int SITES_W    = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [SITES_W-1:0] SITES_RESET   = 5'd16;
   localparam logic               CSR_IDX_SITES = 1'b0;

   localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ACCUM = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef struct packed {
      logic                     valid;
      action_type               action;
      logic [IDX_W-1:0]         idx;
      logic [ACC_W-1:0]         term;
      logic [SITE_W-1:0]        row;
      logic [SITE_W-1:0]        col;
      logic signed [ACC_W-1:0]  value;
      logic                     sat;
   } item_type;

   function automatic logic idx_bit(logic [IDX_W-1:0] idx, int k);
      logic b;
      b = 1'b0;
      if (k < IDX_W) begin
         b = idx[k[IDX_SEL_W-1:0]];
      end
      return b;
   endfunction

endpackage

// ===== rtl/core/szsz_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szsz_front
// squares the amplitude parts and forms the quarter-probability term
// ----------------------------------------------------------------------------
module szsz_front #(
   parameter int AMP_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic [1:0]                           in_action,
   input  logic [szsz_pkg::IDX_W-1:0]           in_idx,
   input  logic signed [AMP_BITS-1:0]           in_amp_re,
   input  logic signed [AMP_BITS-1:0]           in_amp_im,
   input  logic [szsz_pkg::SITE_W-1:0]          in_row,
   input  logic [szsz_pkg::SITE_W-1:0]          in_col,
   output szsz_pkg::item_type                   out_item
);

   localparam int SQ_W = 2 * AMP_BITS;
   localparam int SH_L = (SQ_W <= 48) ? 48 - SQ_W : 0;
   localparam int SH_R = (SQ_W > 48) ? SQ_W - 48 : 0;

   szsz_pkg::item_type    s0_ff, s0_in;
   szsz_pkg::item_type    s1_ff, s1_in;
   logic [SQ_W-1:0]       sq_re_ff, sq_re_in;
   logic [SQ_W-1:0]       sq_im_ff, sq_im_in;
   logic [AMP_BITS-1:0]   raw_re, raw_im, mag_re, mag_im;
   logic [SQ_W:0]         sum;
   szsz_pkg::action_type  act;

   always_comb begin
      act    = szsz_pkg::action_type'(in_action);
      raw_re = $unsigned(in_amp_re);
      raw_im = $unsigned(in_amp_im);
      mag_re = raw_re[AMP_BITS-1] ? AMP_BITS'(~raw_re + 1'b1) : raw_re;
      mag_im = raw_im[AMP_BITS-1] ? AMP_BITS'(~raw_im + 1'b1) : raw_im;
      sq_re_in = SQ_W'(mag_re) * SQ_W'(mag_re);
      sq_im_in = SQ_W'(mag_im) * SQ_W'(mag_im);

      s0_in.valid  = in_valid && (act == szsz_pkg::ACT_CLEAR || act == szsz_pkg::ACT_ACCUM ||
                                  act == szsz_pkg::ACT_READ);
      s0_in.action = act;
      s0_in.idx    = in_idx;
      s0_in.term   = '0;
      s0_in.row    = in_row;
      s0_in.col    = in_col;
      s0_in.value  = '0;
      s0_in.sat    = 1'b0;

      sum        = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
      s1_in      = s0_ff;
      s1_in.term = (szsz_pkg::ACC_W'(sum) << SH_L) >> SH_R;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s0_ff    <= s0_in;
         s1_ff    <= s1_in;
         sq_re_ff <= sq_re_in;
         sq_im_ff <= sq_im_in;
      end
   end

   assign out_item = s1_ff;

endmodule

// ===== rtl/core/szsz_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szsz_cell
// one matrix row of saturating accumulators, one pipeline slot of the chain
// ----------------------------------------------------------------------------
module szsz_cell #(
   parameter int MAX_SITES = 16,
   parameter int ROW       = 0,
   parameter int CNT_W     = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [CNT_W-1:0]    active,
   input  szsz_pkg::item_type  in_item,
   output szsz_pkg::item_type  out_item
);

   logic signed [szsz_pkg::ACC_W-1:0] row_ff [MAX_SITES];
   logic signed [szsz_pkg::ACC_W-1:0] row_in [MAX_SITES];
   logic                              sat_ff, sat_in;
   szsz_pkg::item_type                stage_ff, stage_in;

   logic                              row_act, bit_row, col_ok;
   logic signed [szsz_pkg::ACC_W-1:0] t, sel;
   logic signed [szsz_pkg::ACC_W:0]   s;

   always_comb begin
      row_in   = row_ff;
      sat_in   = sat_ff;
      stage_in = in_item;
      row_act  = ROW < int'(active);
      bit_row  = szsz_pkg::idx_bit(in_item.idx, ROW);
      col_ok   = int'(in_item.col) < int'(active);
      t        = '0;
      s        = '0;
      sel      = '0;
      for (int j = 0; j < MAX_SITES; j++) begin
         if (int'(in_item.col) == j) begin
            sel = row_ff[j];
         end
      end
      if (advance && in_item.valid) begin
         unique case (in_item.action)
            szsz_pkg::ACT_CLEAR: begin
               for (int j = 0; j < MAX_SITES; j++) begin
                  row_in[j] = '0;
               end
               sat_in = 1'b0;
            end
            szsz_pkg::ACT_ACCUM: begin
               if (row_act) begin
                  for (int j = 0; j < MAX_SITES; j++) begin
                     if (j < int'(active)) begin
                        t = (bit_row == szsz_pkg::idx_bit(in_item.idx, j)) ?
                            $signed(in_item.term) : -$signed(in_item.term);
                        s = {row_ff[j][szsz_pkg::ACC_W-1], row_ff[j]} +
                            {t[szsz_pkg::ACC_W-1], t};
                        if (s[szsz_pkg::ACC_W] != s[szsz_pkg::ACC_W-1]) begin
                           row_in[j] = s[szsz_pkg::ACC_W] ? szsz_pkg::ACC_MIN :
                                                            szsz_pkg::ACC_MAX;
                           sat_in    = 1'b1;
                        end else begin
                           row_in[j] = s[szsz_pkg::ACC_W-1:0];
                        end
                     end
                  end
               end
            end
            szsz_pkg::ACT_READ: begin
               if (int'(in_item.row) == ROW && row_act && col_ok) begin
                  stage_in.value = sel;
               end
               stage_in.sat = in_item.sat | sat_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '{default: '0};
         sat_ff         <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         row_ff   <= row_in;
         sat_ff   <= sat_in;
         stage_ff <= stage_in;
      end
   end

   assign out_item = stage_ff;

endmodule

// ===== rtl/core/szsz_correlation_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// szsz_correlation_accumulator
// Sz-Sz correlation matrix accumulator built as a chain of row cells
// ----------------------------------------------------------------------------
//  channel  ports   direction  carries
//  req      req_*   in         clear, accumulate or read request
//  rsp      rsp_*   out        one entry and the sticky saturation flag per read
//  csr      csr_*   in/out     sites_in_use at byte address 0
//
//  one request per cycle; a request walks a squaring stage, a term stage and
//  one cell per row, and a read then lands in the rsp register
//  the whole chain holds while a read sits at its end and the rsp register is
//  full and not taken; a clear or accumulate at the end never waits on rsp
//  reset clears the store and flag directly, no clearing pass
// ----------------------------------------------------------------------------
`include "szsz_correlation_accumulator_defines.svh"

module szsz_correlation_accumulator #(
   parameter int MAX_SITES = 16,
   parameter int AMP_BITS  = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [szsz_pkg::IDX_W-1:0]            req_basis_index,
   input  logic signed [AMP_BITS-1:0]            req_amp_real,
   input  logic signed [AMP_BITS-1:0]            req_amp_imag,
   input  logic [szsz_pkg::SITE_W-1:0]           req_row_site,
   input  logic [szsz_pkg::SITE_W-1:0]           req_col_site,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [szsz_pkg::ACC_W-1:0]     rsp_corr_value,
   output logic                                  rsp_saturated,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [szsz_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [szsz_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [szsz_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_SITES + 1);

   logic [szsz_pkg::SITES_W-1:0]     sites_ff;
   logic [CNT_W-1:0]                 active;
   logic                             advance;
   logic                             tail_read;
   logic                             tail_oor;
   szsz_pkg::item_type               chain [MAX_SITES+1];
   szsz_pkg::item_type               tail;
   logic                             rsp_valid_ff;
   logic signed [szsz_pkg::ACC_W-1:0] rsp_value_ff;
   logic                             rsp_sat_ff;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == szsz_pkg::CSR_IDX_SITES) ?
                       szsz_pkg::CSR_DATA_W'(sites_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sites_ff <= szsz_pkg::SITES_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == szsz_pkg::CSR_IDX_SITES) begin
         sites_ff <= csr_pwdata[szsz_pkg::SITES_W-1:0];
      end
   end

   always_comb begin
      if (int'(sites_ff) > MAX_SITES) begin
         active = CNT_W'(MAX_SITES);
      end else begin
         active = CNT_W'(sites_ff);
      end
   end

   // flow control
   assign tail      = chain[MAX_SITES];
   assign tail_read = tail.valid && tail.action == szsz_pkg::ACT_READ;
   assign tail_oor  = int'(tail.row) >= int'(active) || int'(tail.col) >= int'(active);
   assign advance   = !rsp_valid_ff || rsp_ready || !tail_read;
   assign req_ready = advance;

   szsz_front #(
      .AMP_BITS (AMP_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_action (req_action),
      .in_idx    (req_basis_index),
      .in_amp_re (req_amp_real),
      .in_amp_im (req_amp_imag),
      .in_row    (req_row_site),
      .in_col    (req_col_site),
      .out_item  (chain[0])
   );

   for (genvar g = 0; g < MAX_SITES; g++) begin : g_cell
      szsz_cell #(
         .MAX_SITES (MAX_SITES),
         .ROW       (g),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .active   (active),
         .in_item  (chain[g]),
         .out_item (chain[g+1])
      );
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && tail_read) begin
         rsp_valid_ff <= 1'b1;
         rsp_value_ff <= tail.value;
         rsp_sat_ff   <= tail.sat;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_corr_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;

   `SZSZ_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(tail_read))
   `SZSZ_ASSERT(a_oor_read_zero, (tail_read && tail_oor) |-> tail.value == 64'sd0)
   `SZSZ_ASSERT_NEXT(a_stall_holds_tail, !advance, $stable(tail))

endmodule
